@@ sv/rbt_pkg.sv @@
// Package with shared types and codes of the retransmit buffer table.
package rbt_pkg;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_POLL   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_NOTHING = 2'd0,
		ST_RESEND  = 2'd1,
		ST_FINAL   = 2'd2,
		ST_EVICTED = 2'd3
	} status_t;

	localparam logic CFG_CAPACITY    = 1'b0;
	localparam logic CFG_RETRY_LIMIT = 1'b1;

	typedef struct packed {
		mode_t       mode;
		logic [47:0] sequence_req;
		logic [15:0] pkt_handle;
		logic [31:0] now;
		logic [31:0] send_before;
	} req_t;

endpackage

@@ sv/rbt_front.sv @@
// Front part: accepts requests and queues them for the table engine.
module rbt_front import rbt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_req,
	output logic        q_valid,
	input  logic        q_take,
	output req_t        q_req
);

	// Two-entry queue.
	req_t       mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_stall = cnt_q[1];
	assign push     = in_valid && !in_stall;
	assign q_valid  = cnt_q != 2'd0;
	assign pop      = q_valid && q_take;
	assign q_req    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ sv/rbt_engine.sv @@
// Back part: table storage, list maintenance and result register.
module rbt_engine import rbt_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_take,
	input  req_t        q_req,
	input  logic [6:0]  capacity,
	input  logic [7:0]  retry_limit,
	output logic        out_valid,
	input  logic        out_stall,
	output status_t     status,
	output logic [47:0] out_sequence,
	output logic [15:0] out_handle
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_POLL_RD, S_POLL, S_DROP, S_UNLINK, S_INSERT, S_DONE
	} state_t;

	state_t state_q;
	req_t   req_q;
	logic [ENTRIES-1:0] valid_q;
	// Entry stores; each is read at one address a cycle into a data register.
	logic [47:0] seq_q [ENTRIES];
	logic [15:0] hnd_q [ENTRIES];
	logic [31:0] time_q [ENTRIES];
	logic [7:0]  ret_q [ENTRIES];
	logic [IW-1:0] inx_q [ENTRIES];
	logic [IW-1:0] inp_q [ENTRIES];
	logic [IW-1:0] rsx_q [ENTRIES];
	logic [IW-1:0] rsp_q [ENTRIES];
	logic [47:0] seq_rd_q;
	logic [15:0] hnd_rd_q;
	logic [31:0] time_rd_q;
	logic [7:0]  ret_rd_q;
	logic [IW-1:0] inx_rd_q, inp_rd_q, rsx_rd_q, rsp_rd_q;
	logic [IW-1:0] ih_q, it_q, rh_q, rt_q;
	logic [CW-1:0] count_q;
	logic [IW:0]   scan_q;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q, tgt_q;
	logic          ins_pending_q;
	logic          evict_q;
	logic [IW-1:0] free_idx;
	logic          free_ok;
	logic [CW-1:0] cap_eff;
	logic          out_full_q;
	logic [IW-1:0] sidx, pidx, ra;
	logic          poll_go, poll_last;
	logic          ins_we, keep_we, move_rs;
	logic          inx_we, inp_we, rsx_we, rsp_we;
	logic [IW-1:0] inx_wa, inx_wd, inp_wa, inp_wd;
	logic [IW-1:0] rsx_wa, rsx_wd, rsp_wa, rsp_wd;

	assign sidx = scan_q[IW-1:0];
	assign pidx = IW'(scan_q - 1'b1);

	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_ok  = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	always_comb begin
		if (capacity == 7'd0) cap_eff = CW'(1);
		else if ({25'd0, capacity} > 32'(ENTRIES)) cap_eff = CW'(ENTRIES);
		else cap_eff = CW'(capacity);
	end

	assign q_take    = (state_q == S_IDLE) && !out_full_q;
	assign out_valid = out_full_q;

	assign poll_go   = (count_q != '0) && (time_rd_q < req_q.send_before);
	assign poll_last = ret_rd_q <= 8'd1;
	assign ins_we    = (state_q == S_INSERT) && free_ok;
	assign keep_we   = (state_q == S_POLL) && poll_go && !poll_last;
	assign move_rs   = keep_we && (count_q != CW'(1));

	// Read address: scan position, resend head, or the entry being dropped.
	always_comb begin
		unique case (state_q)
			S_SCAN:    ra = sidx;
			S_POLL_RD: ra = rh_q;
			S_DROP:    ra = tgt_q;
			default:   ra = '0;
		endcase
	end

	// Link writes for append, head-to-tail move and unlink.
	always_comb begin
		inx_we = 1'b0; inx_wa = it_q;     inx_wd = free_idx;
		inp_we = 1'b0; inp_wa = free_idx; inp_wd = it_q;
		rsx_we = 1'b0; rsx_wa = rt_q;     rsx_wd = free_idx;
		rsp_we = 1'b0; rsp_wa = free_idx; rsp_wd = rt_q;
		if (ins_we) begin
			inx_we = count_q != '0;
			inp_we = 1'b1;
			rsx_we = count_q != '0;
			rsp_we = 1'b1;
		end else if (move_rs) begin
			rsx_we = 1'b1; rsx_wa = rt_q; rsx_wd = rh_q;
			rsp_we = 1'b1; rsp_wa = rh_q; rsp_wd = rt_q;
		end else if (state_q == S_UNLINK) begin
			inx_we = tgt_q != ih_q; inx_wa = inp_rd_q; inx_wd = inx_rd_q;
			inp_we = tgt_q != it_q; inp_wa = inx_rd_q; inp_wd = inp_rd_q;
			rsx_we = tgt_q != rh_q; rsx_wa = rsp_rd_q; rsx_wd = rsx_rd_q;
			rsp_we = tgt_q != rt_q; rsp_wa = rsx_rd_q; rsp_wd = rsp_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_we) begin
			seq_q[free_idx] <= req_q.sequence_req;
			hnd_q[free_idx] <= req_q.pkt_handle;
		end
		seq_rd_q <= seq_q[ra];
		hnd_rd_q <= hnd_q[ra];
	end

	always_ff @(posedge clk) begin
		if (ins_we) begin
			time_q[free_idx] <= req_q.now;
			ret_q[free_idx]  <= retry_limit;
		end else if (keep_we) begin
			time_q[rh_q] <= req_q.now;
			ret_q[rh_q]  <= ret_rd_q - 8'd1;
		end
		time_rd_q <= time_q[ra];
		ret_rd_q  <= ret_q[ra];
	end

	always_ff @(posedge clk) begin
		if (inx_we) inx_q[inx_wa] <= inx_wd;
		if (inp_we) inp_q[inp_wa] <= inp_wd;
		if (rsx_we) rsx_q[rsx_wa] <= rsx_wd;
		if (rsp_we) rsp_q[rsp_wa] <= rsp_wd;
		inx_rd_q <= inx_q[ra];
		inp_rd_q <= inp_q[ra];
		rsx_rd_q <= rsx_q[ra];
		rsp_rd_q <= rsp_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			req_q      <= '0;
			valid_q    <= '0;
			count_q    <= '0;
			out_full_q <= 1'b0;
			ih_q <= '0; it_q <= '0; rh_q <= '0; rt_q <= '0;
			status       <= ST_NOTHING;
			out_sequence <= '0;
			out_handle   <= '0;
			scan_q <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			tgt_q <= '0;
			ins_pending_q <= 1'b0;
			evict_q <= 1'b0;
		end else begin
			if (out_full_q && !out_stall) out_full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid && !out_full_q) begin
						req_q        <= q_req;
						status       <= ST_NOTHING;
						out_sequence <= '0;
						out_handle   <= '0;
						scan_q       <= '0;
						hit_q        <= 1'b0;
						ins_pending_q <= 1'b0;
						evict_q      <= 1'b0;
						unique case (q_req.mode)
							MODE_INSERT, MODE_REMOVE: state_q <= S_SCAN;
							MODE_POLL:                state_q <= S_POLL_RD;
							default:                  state_q <= S_DONE;
						endcase
					end
				end
				// Associative search, one entry a cycle: the entry read on the
				// previous cycle is compared while the next one is read.
				S_SCAN: begin
					if (scan_q != '0 && valid_q[pidx] && seq_rd_q == req_q.sequence_req) begin
						hit_q     <= 1'b1;
						hit_idx_q <= pidx;
						state_q   <= S_DECIDE;
					end else if (scan_q == (IW+1)'(ENTRIES)) begin
						state_q <= S_DECIDE;
					end
					scan_q <= scan_q + 1'b1;
				end
				S_DECIDE: begin
					if (req_q.mode == MODE_REMOVE) begin
						if (hit_q) begin
							tgt_q   <= hit_idx_q;
							state_q <= S_DROP;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						ins_pending_q <= !hit_q;
						if ((count_q + CW'(!hit_q)) > cap_eff && count_q != '0) begin
							status  <= ST_EVICTED;
							evict_q <= 1'b1;
							tgt_q   <= ih_q;
							state_q <= S_DROP;
						end else begin
							state_q <= hit_q ? S_DONE : S_INSERT;
						end
					end
				end
				S_INSERT: begin
					if (free_ok) begin
						valid_q[free_idx] <= 1'b1;
						if (count_q == '0) begin
							ih_q <= free_idx;
							rh_q <= free_idx;
						end
						it_q <= free_idx;
						rt_q <= free_idx;
						count_q <= count_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_POLL_RD: begin
					state_q <= S_POLL;
				end
				S_POLL: begin
					if (poll_go) begin
						out_sequence <= seq_rd_q;
						out_handle   <= hnd_rd_q;
						if (poll_last) begin
							status  <= ST_FINAL;
							tgt_q   <= rh_q;
							state_q <= S_DROP;
						end else begin
							status <= ST_RESEND;
							// Move head to tail of resend order.
							if (count_q != CW'(1)) begin
								rh_q <= rsx_rd_q;
								rt_q <= rh_q;
							end
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DROP: begin
					state_q <= S_UNLINK;
				end
				// Unlink from both lists; head/tail tests decide which links move.
				S_UNLINK: begin
					valid_q[tgt_q] <= 1'b0;
					count_q <= count_q - 1'b1;
					if (evict_q) begin
						out_sequence <= seq_rd_q;
						out_handle   <= hnd_rd_q;
					end
					if (tgt_q == ih_q) ih_q <= inx_rd_q;
					if (tgt_q == it_q) it_q <= inp_rd_q;
					if (tgt_q == rh_q) rh_q <= rsx_rd_q;
					if (tgt_q == rt_q) rt_q <= rsp_rd_q;
					state_q <= ins_pending_q ? S_INSERT : S_DONE;
					ins_pending_q <= 1'b0;
				end
				S_DONE: begin
					out_full_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/retransmit_buffer_table_top.sv @@
// Top level of the retransmit buffer table.
// The block keeps sent packets keyed by a 48-bit sequence number, in both
// insertion order and resend order, for link-layer retransmission.
// Requests arrive on in_valid/in_stall with mode, sequence_req, pkt_handle,
// now and send_before; a request is taken on an edge with in_valid high and
// in_stall low. Every request gives exactly one result on out_valid/out_stall
// carrying status, out_sequence and out_handle.
// A two-deep queue separates the accepting front from the table engine, so
// up to two requests can wait while a result is held by the receiver.
// A poll reads the resend head directly, with no search. An insert or remove reads
// the table one entry a cycle until it finds the sequence number or reaches the end,
// and an insert may then evict the oldest entry to stay within capacity. One request
// is handled at a time, and the engine takes the next in the cycle after its result
// has been accepted.
// Configuration (capacity, retry_limit) is written through cfg_we, cfg_index and cfg_data;
// the user must write it only while the block is idle, as the block does not enforce this.
// Reset empties the table and both orders and restores the register defaults.
// When the receiver stalls, the result is held and the engine waits.
module retransmit_buffer_table_top import rbt_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [47:0] sequence_req,
	input  logic [15:0] pkt_handle,
	input  logic [31:0] now,
	input  logic [31:0] send_before,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [47:0] out_sequence,
	output logic [15:0] out_handle
);

	logic [6:0] capacity_q;
	logic [7:0] retry_limit_q;
	req_t       in_req, q_req;
	logic       q_valid, q_take;
	status_t    status_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q    <= 7'd64;
			retry_limit_q <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAPACITY:    capacity_q    <= cfg_data[6:0];
				CFG_RETRY_LIMIT: retry_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_req = '{mode: mode_t'(mode), sequence_req: sequence_req,
		pkt_handle: pkt_handle, now: now, send_before: send_before};

	rbt_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_req(in_req), .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
	);

	rbt_engine #(.ENTRIES(ENTRIES)) u_engine (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_req(q_req), .capacity(capacity_q), .retry_limit(retry_limit_q),
		.out_valid(out_valid), .out_stall(out_stall), .status(status_w),
		.out_sequence(out_sequence), .out_handle(out_handle)
	);

	assign status = status_w;

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_sequence))
		else $error("result changed while stalled");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> !out_valid)
		else $error("engine took a request with result pending");
`endif

endmodule
